>>> src/spcr_pkg.sv
`timescale 1ns / 1ps

package spcr_pkg;

	localparam int HEADER_BYTES = 4;

	localparam logic [7:0] SYNC_CODE = 8'h55;

	localparam logic [15:0] CAPACITY_RESET = 16'd1024;
	localparam logic [7:0]  POLY_RESET     = 8'h07;

	// configuration register indexes
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_POLY     = 1'b1;

	// result status codes
	localparam logic [1:0] ST_WAIT    = 2'd0;
	localparam logic [1:0] ST_OK      = 2'd1;
	localparam logic [1:0] ST_BAD_CRC = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic        byte_valid;
		logic [16:0] byte_index;
		logic [7:0]  byte_value;
		logic [15:0] data_length;
		logic [7:0]  option_length;
		logic [7:0]  packet_type;
	} res_t;

	// CRC8, MSB first, one byte
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> src/serial_packet_crc8_receiver_top.sv
`timescale 1ns / 1ps

// Serial packet receiver: takes one received byte per cycle while in_stall is low and
// checks frames of sync 0x55, four header bytes (data length high/low, option length,
// packet type), header CRC8, payload and payload CRC8. Every accepted byte yields exactly
// one result word, registered in the output buffer; the whole byte is handled by
// combinational logic, with the header CRC recompute on resync (four chained CRC8 byte
// updates) as the longest path. A two-word output buffer lets a byte be taken every cycle
// while a result waits; in_stall rises only when both buffer slots are full. Configuration
// (capacity at index 0, polynomial at 1) should be written only while idle.
module serial_packet_crc8_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        gap_timeout,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        byte_valid,
	output logic [16:0] byte_index,
	output logic [7:0]  byte_value,
	output logic [15:0] data_length,
	output logic [7:0]  option_length,
	output logic [7:0]  packet_type,
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import spcr_pkg::*;

	logic accept, full;
	res_t res, out_res;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	spcr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.gap_timeout(gap_timeout),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res        (res)
	);

	spcr_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(res),
		.full     (full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_res)
	);

	assign status        = out_res.status;
	assign byte_valid    = out_res.byte_valid;
	assign byte_index    = out_res.byte_index;
	assign byte_value    = out_res.byte_value;
	assign data_length   = out_res.data_length;
	assign option_length = out_res.option_length;
	assign packet_type   = out_res.packet_type;

endmodule

>>> src/spcr_core.sv
`timescale 1ns / 1ps

module spcr_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	input  logic          gap_timeout,
	input  logic          cfg_wen,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data,
	output spcr_pkg::res_t res
);
	import spcr_pkg::*;

	localparam logic [2:0] PH_SYNC   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_HCRC   = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_DCRC   = 3'd4;

	logic [15:0] capacity_q;
	logic [7:0]  poly_q;
	logic [2:0]  phase_q, phase_n, ph;
	logic [7:0]  crc_q, crc_n;
	logic [16:0] cnt_q, cnt_n, cnt_inc, total;
	logic [7:0]  hdr_q [HEADER_BYTES];
	logic [7:0]  hdr_n [HEADER_BYTES];
	logic [7:0]  s3, s23, s123, b;
	logic [1:0]  status;
	logic        bvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			poly_q     <= POLY_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_CAPACITY: capacity_q <= cfg_data;
				REG_POLY:     poly_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign b       = rx_byte;
	assign ph      = gap_timeout ? PH_SYNC : phase_q;
	assign cnt_inc = cnt_q + 17'd1;
	assign total   = {1'b0, hdr_q[0], hdr_q[1]} + {9'd0, hdr_q[2]};

	// CRC of the header tails that survive a resync
	assign s3   = crc8_update(8'd0, hdr_q[3], poly_q);
	assign s23  = crc8_update(crc8_update(8'd0, hdr_q[2], poly_q), hdr_q[3], poly_q);
	assign s123 = crc8_update(crc8_update(crc8_update(8'd0, hdr_q[1], poly_q), hdr_q[2],
		poly_q), hdr_q[3], poly_q);

	always_comb begin
		phase_n = ph;
		crc_n   = crc_q;
		cnt_n   = cnt_q;
		for (int i = 0; i < HEADER_BYTES; i++) begin
			hdr_n[i] = hdr_q[i];
		end
		status = ST_WAIT;
		bvalid = 1'b0;
		res.byte_index = '0;
		res.byte_value = '0;

		unique case (ph)
			PH_HEADER: begin
				hdr_n[cnt_q[1:0]] = b;
				cnt_n = cnt_inc;
				crc_n = crc8_update(crc_q, b, poly_q);
				if (cnt_inc >= 17'(HEADER_BYTES)) begin
					phase_n = PH_HCRC;
				end
			end
			PH_HCRC: begin
				if (crc_q != b) begin
					if (hdr_q[0] == SYNC_CODE) begin
						hdr_n[0] = hdr_q[1];
						hdr_n[1] = hdr_q[2];
						hdr_n[2] = hdr_q[3];
						hdr_n[3] = b;
						cnt_n    = 17'd4;
						crc_n    = crc8_update(s123, b, poly_q);
						phase_n  = PH_HCRC;
					end else if (hdr_q[1] == SYNC_CODE) begin
						hdr_n[0] = hdr_q[2];
						hdr_n[1] = hdr_q[3];
						hdr_n[2] = b;
						cnt_n    = 17'd3;
						crc_n    = crc8_update(s23, b, poly_q);
						phase_n  = PH_HEADER;
					end else if (hdr_q[2] == SYNC_CODE) begin
						hdr_n[0] = hdr_q[3];
						hdr_n[1] = b;
						cnt_n    = 17'd2;
						crc_n    = crc8_update(s3, b, poly_q);
						phase_n  = PH_HEADER;
					end else if (hdr_q[3] == SYNC_CODE) begin
						hdr_n[0] = b;
						cnt_n    = 17'd1;
						crc_n    = crc8_update(8'd0, b, poly_q);
						phase_n  = PH_HEADER;
					end else if (b == SYNC_CODE) begin
						phase_n = PH_HEADER;
						cnt_n   = '0;
						crc_n   = '0;
					end else begin
						phase_n = PH_SYNC;
					end
				end else if (total == '0) begin
					if (b == SYNC_CODE) begin
						phase_n = PH_HEADER;
						cnt_n   = '0;
						crc_n   = '0;
					end else begin
						phase_n = PH_SYNC;
						status  = ST_RANGE;
					end
				end else begin
					phase_n = PH_DATA;
					cnt_n   = '0;
					crc_n   = '0;
				end
			end
			PH_DATA: begin
				if (cnt_q < {1'b0, capacity_q}) begin
					crc_n  = crc8_update(crc_q, b, poly_q);
					bvalid = 1'b1;
					res.byte_index = cnt_q;
					res.byte_value = b;
				end
				cnt_n = cnt_inc;
				if (cnt_inc == total) begin
					phase_n = PH_DCRC;
				end
			end
			PH_DCRC: begin
				phase_n = PH_SYNC;
				if (cnt_q > {1'b0, capacity_q}) begin
					status = ST_RANGE;
				end else if (crc_q == b) begin
					status = ST_OK;
				end else begin
					status = ST_BAD_CRC;
					if (b == SYNC_CODE) begin
						phase_n = PH_HEADER;
						cnt_n   = '0;
						crc_n   = '0;
					end
				end
			end
			PH_SYNC: begin
				if (b == SYNC_CODE) begin
					phase_n = PH_HEADER;
					cnt_n   = '0;
					crc_n   = '0;
				end
			end
			default: begin
				phase_n = PH_SYNC;
			end
		endcase

		res.status     = status;
		res.byte_valid = bvalid;
		if (status != ST_WAIT || phase_n == PH_DATA || phase_n == PH_DCRC) begin
			res.data_length   = {hdr_n[0], hdr_n[1]};
			res.option_length = hdr_n[2];
			res.packet_type   = hdr_n[3];
		end else begin
			res.data_length   = '0;
			res.option_length = '0;
			res.packet_type   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			crc_q   <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			crc_q   <= crc_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < HEADER_BYTES; i++) begin
				hdr_q[i] <= hdr_n[i];
			end
		end
	end

endmodule

>>> src/spcr_out_buf.sv
`timescale 1ns / 1ps

module spcr_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  spcr_pkg::res_t push_data,
	output logic           full,
	output logic           out_valid,
	input  logic           out_stall,
	output spcr_pkg::res_t out_data
);
	import spcr_pkg::*;

	logic main_v_q, skid_v_q, pop;
	res_t main_q, skid_q;

	assign pop       = main_v_q && !out_stall;
	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	// a word lands in the skid slot only when the main slot is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || pop) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
